/* rtl/core/rrq_pkg.sv */
// Package for the reversible ring queue: parameter defaults, command and
// status codes, payload structs and the controller/datapath link types.
// No dependencies.
package rrq_pkg;

    // Default sizing, used as the top level and datapath parameter defaults
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Item kinds
    typedef enum logic [1:0] {
        K_PUSH = 2'd0,
        K_POP  = 2'd1,
        K_REV  = 2'd2,
        K_READ = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Input item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [6:0]  index;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [31:0] data_out;
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [6:0]  item_count;
        logic        is_reversed;
        t_status     status;
    } t_out_item;

    // RAM read address source
    typedef enum logic [1:0] {
        RD_EXEC  = 2'd0,
        RD_FIRST = 2'd1,
        RD_LAST  = 2'd2
    } t_rd_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    exec;
        logic    cap_data;
        logic    cap_first;
        logic    ld_out;
        t_rd_sel rd_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/rrq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rrq_ctrl.sv */
// Sequencer for the reversible ring queue: takes one item, then steps the
// datapath through execute and three RAM reads. Uses rrq_pkg.
module rrq_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  rrq_pkg::t_sts i_sts,
    output rrq_pkg::t_cmd o_cmd
);
    import rrq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD1  = 5'b00100,
        S_RD2  = 5'b01000,
        S_RD3  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = RD_EXEC;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.rd_sel = RD_EXEC;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.cap_data = 1'b1;
                o_cmd.rd_sel   = RD_FIRST;
                n_state        = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_sel    = RD_LAST;
                n_state         = S_RD3;
            end
            S_RD3: begin
                // hold here until the output register can take the result
                o_cmd.rd_sel = RD_LAST;
                o_cmd.ld_out = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/core/rrq_dpath.sv */
// Datapath for the reversible ring queue: pointers, count, direction flag,
// storage RAM and the output register. Uses rrq_pkg and rrq_ram.
module rrq_dpath #(
    parameter int DEPTH      = rrq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rrq_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrq_pkg::t_in_item  i_in_data,
    input  rrq_pkg::t_cmd      i_cmd,
    output rrq_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrq_pkg::t_out_item o_out_data
);
    import rrq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > 7) ? CW : 7;
    localparam logic [AW:0]    DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]  LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);

    // Wrap a position sum that stays below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
        return t[AW-1:0];
    endfunction

    t_in_item        r_in;
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic            r_rev;
    t_status         r_status;
    logic            r_data_ok;
    logic [31:0]     r_data;
    logic [31:0]     r_first;
    t_out_item       r_out;
    logic            r_out_valid;

    logic [AW-1:0]   n_head;
    logic [CW-1:0]   n_count;
    logic            n_rev;
    t_status         n_status;
    logic            n_data_ok;

    logic [AW-1:0]   last_off;
    logic [AW-1:0]   last_addr;
    logic [AW-1:0]   tail_addr;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   head_dec;
    logic [IW-1:0]   idx_w;
    logic            idx_ok;
    logic [AW-1:0]   idx_addr;
    logic [AW-1:0]   ex_raddr;
    logic [AW-1:0]   raddr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [31:0]     rd32;
    logic            out_free;
    logic            has_items;
    t_out_item       out_next;

    // Positions derived from the current pointers
    assign last_off  = (r_count == '0) ? '0 : AW'(r_count - CW'(1));
    assign last_addr = wrap({1'b0, r_head} + {1'b0, last_off});
    assign tail_addr = wrap({1'b0, r_head} + {1'b0, AW'(r_count)});
    assign head_inc  = wrap({1'b0, r_head} + (AW + 1)'(1));
    assign head_dec  = (r_head == '0) ? LAST_POS : (r_head - AW'(1));
    assign idx_w     = IW'(r_in.index);
    assign idx_ok    = (idx_w != '0) && (idx_w <= IW'(r_count));
    assign idx_addr  = wrap({1'b0, r_head} + {1'b0, AW'(idx_w - IW'(1))});

    // Execute one item on the pointers and count
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_rev     = r_rev;
        n_status  = ST_OK;
        n_data_ok = 1'b0;
        ex_raddr  = r_head;
        we        = 1'b0;
        waddr     = tail_addr;
        case (r_in.kind)
            K_PUSH: begin
                if (r_count == FULL_CNT) begin
                    n_status = ST_FULL;
                end else begin
                    we      = i_cmd.exec;
                    n_count = r_count + CW'(1);
                    if (r_rev) begin
                        waddr  = head_dec;
                        n_head = head_dec;
                    end
                end
            end
            K_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data_ok = 1'b1;
                    n_count   = r_count - CW'(1);
                    if (r_rev) begin
                        ex_raddr = last_addr;
                    end else begin
                        n_head = head_inc;
                    end
                end
            end
            K_REV: begin
                n_rev = ~r_rev;
            end
            K_READ: begin
                if (idx_ok) begin
                    n_data_ok = 1'b1;
                    ex_raddr  = idx_addr;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Select the RAM read address for this step
    always_comb begin
        case (i_cmd.rd_sel)
            RD_EXEC:  raddr = ex_raddr;
            RD_FIRST: raddr = r_head;
            RD_LAST:  raddr = last_addr;
            default:  raddr = r_head;
        endcase
    end

    rrq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (DATA_WIDTH'(r_in.value)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd32      = 32'(rdata);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign has_items = (r_count != '0);

    // Assemble the result; read data now holds the physical last word
    always_comb begin
        out_next             = '0;
        out_next.data_out    = r_data;
        out_next.front_value = has_items ? (r_rev ? rd32 : r_first) : '0;
        out_next.back_value  = has_items ? (r_rev ? r_first : rd32) : '0;
        out_next.item_count  = 7'(r_count);
        out_next.is_reversed = r_rev;
        out_next.status      = r_status;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_rev   <= n_rev;
            end
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_data_ok <= n_data_ok;
        end
        if (i_cmd.cap_data) begin
            r_data <= r_data_ok ? rd32 : '0;
        end
        if (i_cmd.cap_first) begin
            r_first <= rd32;
        end
        if (i_cmd.ld_out) begin
            r_out <= out_next;
        end
    end

    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    // Fill level never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill level beyond capacity");

    // Head pointer stays inside the ring
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_W)
        else $error("head pointer outside ring");

    // Queue state moves only on an execute step
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_count) && $stable(r_head) && $stable(r_rev)))
        else $error("queue state changed outside execute");

    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

/* rtl/core/reversible_ring_queue.sv */
// Top level of the reversible ring queue: joins the sequencer and datapath.
// Uses rrq_pkg, rrq_ctrl and rrq_dpath.
//
// Input channel: i_in_valid / o_in_stall carry one item (kind, value,
// index) per transfer. Kinds are push at the logical back, pop from the
// logical front, reverse direction, and read by one-based storage position.
// Output channel: o_out_valid / i_out_stall carry one result per item: the
// popped or read word, front and back words, fill level, direction flag
// and status.
// Each item steps through S_EXEC, S_RD1, S_RD2 and S_RD3 before its result
// is registered, and no new item is accepted until then. It takes an execute
// step and three reads through the single storage RAM read port (item word,
// physical first word, physical last word).
// A finished result sits in its own output register, so the next item is
// taken while that result waits. If the receiver still stalls when the
// following result is ready, that item holds in its last step and no new
// item is accepted until the output register frees.
// Reset (synchronous, active low) empties the queue, sets forward
// direction and drops any pending result. Storage contents are not cleared;
// only words from occupied slots ever reach a result.
module reversible_ring_queue #(
    parameter int DEPTH      = rrq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rrq_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rrq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrq_pkg::t_out_item o_out_data
);
    import rrq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the reversible ring queue: directed corner cases,
// fill/drain passes and paced random traffic against a cycle-free queue predictor.
// Depends on rrq_pkg and the reversible_ring_queue top level.
module tb_top;
    import rrq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    // Predicted queue state
    logic [31:0] q_mem [QDEPTH];
    logic [5:0]  q_head;
    logic [6:0]  q_fill;
    logic        q_rev;

    t_out_item   pending_results [$];
    t_out_item   exp_res;
    int          errors;
    int          cycle_count;
    int          results_seen;
    int          kind_sent [4];
    int          status_seen [4];
    int          max_fill_seen;
    int          burst_left;
    bit          pace_on;

    reversible_ring_queue i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_item)
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("reversible_ring_queue regression: fail");
        $finish;
    end

    // Apply one item to the predicted queue and return the expected result
    function automatic t_out_item queue_step(t_in_item it);
        t_out_item   r;
        logic [5:0]  pos;
        logic [6:0]  off;
        logic [31:0] first_w;
        logic [31:0] last_w;
        r = '0;
        r.status = ST_OK;
        case (it.kind)
            K_PUSH: begin
                if (q_fill == 7'(QDEPTH)) begin
                    r.status = ST_FULL;
                end else if (q_rev) begin
                    q_head = q_head - 6'd1;
                    q_mem[q_head] = it.value;
                    q_fill = q_fill + 7'd1;
                end else begin
                    pos = q_head + q_fill[5:0];
                    q_mem[pos] = it.value;
                    q_fill = q_fill + 7'd1;
                end
            end
            K_POP: begin
                if (q_fill == 7'd0) begin
                    r.status = ST_EMPTY;
                end else if (q_rev) begin
                    off = q_fill - 7'd1;
                    pos = q_head + off[5:0];
                    r.data_out = q_mem[pos];
                    q_fill = q_fill - 7'd1;
                end else begin
                    r.data_out = q_mem[q_head];
                    q_head = q_head + 6'd1;
                    q_fill = q_fill - 7'd1;
                end
            end
            K_REV: begin
                q_rev = ~q_rev;
            end
            default: begin
                if (it.index >= 7'd1 && it.index <= q_fill) begin
                    off = it.index - 7'd1;
                    pos = q_head + off[5:0];
                    r.data_out = q_mem[pos];
                end else begin
                    r.status = ST_RANGE;
                end
            end
        endcase
        // Front and back follow the direction flag
        first_w = '0;
        last_w  = '0;
        if (q_fill != 7'd0) begin
            off = q_fill - 7'd1;
            pos = q_head + off[5:0];
            first_w = q_mem[q_head];
            last_w  = q_mem[pos];
        end
        r.front_value = q_rev ? last_w : first_w;
        r.back_value  = q_rev ? first_w : last_w;
        r.item_count  = q_fill;
        r.is_reversed = q_rev;
        return r;
    endfunction

    function automatic t_in_item make_item(t_kind k, logic [31:0] v, logic [6:0] ix);
        t_in_item it;
        it.kind  = k;
        it.value = v;
        it.index = ix;
        return it;
    endfunction

    // Drive one item and hold it until the transfer, then record its result
    task automatic send_item(t_in_item it);
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(queue_step(it));
        kind_sent[it.kind]++;
        if (q_fill > max_fill_seen)
            max_fill_seen = q_fill;
    endtask

    // Send with burst pacing: random gaps between bursts when pacing is on
    task automatic send_paced(t_in_item it);
        if (pace_on && burst_left == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        send_item(it);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic report_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
            end else begin
                exp_res = pending_results.pop_front();
                results_seen++;
                status_seen[exp_res.status]++;
                report_field("data_out", exp_res.data_out, out_item.data_out);
                report_field("front_value", exp_res.front_value, out_item.front_value);
                report_field("back_value", exp_res.back_value, out_item.back_value);
                report_field("item_count", 32'(exp_res.item_count), 32'(out_item.item_count));
                report_field("is_reversed", 32'(exp_res.is_reversed),
                             32'(out_item.is_reversed));
                report_field("status", 32'(exp_res.status), 32'(out_item.status));
            end
        end
    end

    // Receiver stall pattern: switch between none, light, heavy and periodic
    initial begin : stall_gen
        int mode;
        int left;
        int phase;
        mode  = 0;
        left  = 0;
        phase = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            phase++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ((phase % 8) < 3);
            endcase
        end
    end

    // Corner cases: empty queue, wrap on reversed push, extreme words and indexes
    task automatic test_directed();
        send_item(make_item(K_POP, 32'h1234_5678, 7'd0));
        send_item(make_item(K_READ, '0, 7'd0));
        send_item(make_item(K_READ, '0, 7'd1));
        send_item(make_item(K_REV, '0, 7'd0));
        send_item(make_item(K_POP, '0, 7'd0));
        send_item(make_item(K_REV, '0, 7'd0));
        send_item(make_item(K_PUSH, 32'h0000_0000, 7'd0));
        send_item(make_item(K_PUSH, 32'hFFFF_FFFF, 7'd127));
        send_item(make_item(K_PUSH, 32'h5555_5555, 7'd64));
        send_item(make_item(K_REV, 32'hFFFF_FFFF, 7'd0));
        // Head wraps below slot zero here
        send_item(make_item(K_PUSH, 32'hAAAA_AAAA, 7'd0));
        send_item(make_item(K_READ, '0, 7'd1));
        send_item(make_item(K_READ, '0, 7'd4));
        send_item(make_item(K_READ, '0, 7'd5));
        send_item(make_item(K_READ, '0, 7'd0));
        send_item(make_item(K_READ, '0, 7'd127));
        send_item(make_item(K_READ, '0, 7'd64));
        send_item(make_item(K_POP, '0, 7'd0));
        send_item(make_item(K_REV, '0, 7'd0));
        send_item(make_item(K_POP, '0, 7'd0));
        send_item(make_item(K_POP, '0, 7'd0));
        send_item(make_item(K_POP, '0, 7'd0));
        send_item(make_item(K_POP, '0, 7'd0));
        drain_results();
    endtask

    // Fill to capacity in a random mix of directions, refuse extra pushes, then drain
    task automatic test_fill_drain(bit start_rev);
        if (q_rev != start_rev)
            send_paced(make_item(K_REV, $urandom, 7'($urandom)));
        while (q_fill < 7'(QDEPTH)) begin
            if ($urandom_range(0, 99) < 5)
                send_paced(make_item(K_REV, $urandom, 7'($urandom)));
            send_paced(make_item(K_PUSH, $urandom, 7'($urandom)));
        end
        repeat (3) send_paced(make_item(K_PUSH, $urandom, 7'($urandom)));
        send_paced(make_item(K_READ, $urandom, 7'd64));
        send_paced(make_item(K_READ, $urandom, 7'd65));
        send_paced(make_item(K_READ, $urandom, 7'd1));
        send_paced(make_item(K_REV, $urandom, 7'($urandom)));
        send_paced(make_item(K_PUSH, $urandom, 7'($urandom)));
        while (q_fill != 7'd0) begin
            if ($urandom_range(0, 99) < 5)
                send_paced(make_item(K_REV, $urandom, 7'($urandom)));
            if ($urandom_range(0, 99) < 10)
                send_paced(make_item(K_READ, $urandom, 7'($urandom_range(1, q_fill))));
            send_paced(make_item(K_POP, $urandom, 7'($urandom)));
        end
        send_paced(make_item(K_POP, $urandom, 7'($urandom)));
        drain_results();
    endtask

    // Random traffic steered toward a wandering fill target
    task automatic test_random(int n_items);
        int       target;
        int       r;
        int       span;
        t_kind    k;
        logic [6:0] ix;
        target = 32;
        span   = 0;
        for (int i = 0; i < n_items; i++) begin
            if (span == 0) begin
                r = $urandom_range(0, 3);
                target = (r == 0) ? 0 : (r == 1) ? QDEPTH : $urandom_range(0, QDEPTH);
                span = $urandom_range(20, 120);
                pace_on = ($urandom_range(0, 3) != 0);
            end
            span--;
            if (i == n_items / 2)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                k = K_REV;
            end else if (r < 30) begin
                k = K_READ;
            end else if ((q_fill < target) ^ ($urandom_range(0, 99) < 15)) begin
                k = K_PUSH;
            end else begin
                k = K_POP;
            end
            r = $urandom_range(0, 99);
            if (k == K_READ && r < 60 && q_fill != 7'd0)
                ix = 7'($urandom_range(1, q_fill));
            else if (k == K_READ && r < 75)
                ix = (r < 68) ? 7'd0 : q_fill + 7'd1;
            else
                ix = 7'($urandom);
            send_paced(make_item(k, $urandom, ix));
        end
        pace_on = 1'b1;
        drain_results();
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        q_head   = '0;
        q_fill   = '0;
        q_rev    = 1'b0;
        errors   = 0;
        results_seen  = 0;
        max_fill_seen = 0;
        burst_left    = 0;
        pace_on       = 1'b1;
        for (int i = 0; i < 4; i++) begin
            kind_sent[i]   = 0;
            status_seen[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_drain(1'b0);
        test_fill_drain(1'b1);
        test_random(1250);

        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        $display("Covered %0d push, %0d pop, %0d reverse, %0d read items; %0d results checked.",
                 kind_sent[K_PUSH], kind_sent[K_POP], kind_sent[K_REV], kind_sent[K_READ],
                 results_seen);
        $display("Statuses ok/empty/full/range: %0d/%0d/%0d/%0d, peak fill %0d, %0d errors.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_RANGE], max_fill_seen, errors);
        if (errors == 0)
            $display("reversible_ring_queue regression: pass");
        else
            $display("reversible_ring_queue regression: fail");
        $finish;
    end

endmodule
